>>> rtl/core/trg_pkg.sv
package trg_pkg;

    localparam int OUT_W      = 16;
    localparam int GRADE_W    = 5;
    localparam int M_TDATA_W  = 56;
    localparam int S_TDATA_W  = 8;

    localparam logic [7:0] C_TAB      = 8'd9;
    localparam logic [7:0] C_CR       = 8'd13;
    localparam logic [7:0] C_SPACE    = 8'd32;
    localparam logic [7:0] C_UPPER_A  = 8'd65;
    localparam logic [7:0] C_UPPER_Z  = 8'd90;
    localparam logic [7:0] C_LOWER_A  = 8'd97;
    localparam logic [7:0] C_LOWER_Z  = 8'd122;
    localparam logic [7:0] C_PERIOD   = 8'd46;
    localparam logic [7:0] C_BANG     = 8'd33;
    localparam logic [7:0] C_QUESTION = 8'd63;

    localparam int C_LETTER_COEF   = 588;
    localparam int C_SENTENCE_COEF = 2960;
    localparam int C_GRADE_OFFSET  = 1530;
    localparam int C_GRADE_STEP    = 100;
    localparam int C_GRADE_MAX     = 16;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_ADJ,
        ST_GRADE
    } trg_state_t;

    typedef struct packed {
        logic count_en;
        logic snap;
        logic mul_en;
        logic div_load;
        logic div_step;
        logic adj_en;
        logic out_load;
    } trg_cmd_t;

    typedef struct packed {
        logic div_last;
    } trg_sts_t;

endpackage

>>> rtl/core/text_readability_grader_unit.sv
// Text bytes are taken one per cycle while the unit is counting.
// The transaction with tlast set starts the grade computation: s_axis_tready stays low while
// the products, the numerator load, the bit-serial divider, the offset adjust and the output
// register follow in turn, and the result then appears on m_axis_tvalid.
// The result waits in an output register, and counting resumes while it is pending.
// Synchronous active-low reset clears the counters, the state machine and the output valid.
module text_readability_grader_unit
    import trg_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_code
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] letter_total, [31:16] word_total, [47:32] sentence_total, [52:48] grade
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser   // [0] no_words
);

    trg_cmd_t cmd;
    trg_sts_t sts;

    trg_controller u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid)
    );

    trg_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

>>> rtl/core/trg_controller.sv
module trg_controller
    import trg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_axis_tvalid,
    input  logic     s_axis_tlast,
    input  logic     m_axis_tready,
    input  trg_sts_t sts,
    output trg_cmd_t cmd,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid
);

    trg_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_axis_tready = 1'b1;
                cmd.count_en  = s_axis_tvalid;
                cmd.snap      = s_axis_tvalid && s_axis_tlast;
                if (s_axis_tvalid && s_axis_tlast) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                cmd.adj_en = 1'b1;
                state_next = ST_GRADE;
            end
            ST_GRADE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule

>>> rtl/core/trg_datapath.sv
module trg_datapath
    import trg_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  trg_cmd_t             cmd,
    output trg_sts_t             sts,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser
);

    localparam int PL_W  = COUNT_BITS + 10;
    localparam int PS_W  = COUNT_BITS + 12;
    localparam int NUM_W = COUNT_BITS + 13;
    localparam int T_W   = NUM_W + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int PAD_W = M_TDATA_W - 3 * OUT_W - GRADE_W;

    logic [COUNT_BITS-1:0] letter_reg, letter_next;
    logic [COUNT_BITS-1:0] word_reg, word_next;
    logic [COUNT_BITS-1:0] sent_reg, sent_next;
    logic                  inword_reg, inword_next;

    logic [COUNT_BITS-1:0] l_op_reg, w_op_reg, s_op_reg;
    logic [PL_W-1:0]       prod_l_reg;
    logic [PS_W-1:0]       prod_s_reg;
    logic                  neg_reg;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [T_W-1:0] t_reg;

    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  out_user_reg;

    logic [7:0]            ch;
    logic                  is_letter, is_blank, is_mark;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]      num_mag;
    logic [COUNT_BITS:0]   shifted, trial;
    logic signed [NUM_W:0] q_signed;
    logic [GRADE_W-1:0]    grade;
    logic                  no_words;
    logic [OUT_W-1:0]      letter_out, word_out, sent_out;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    assign ch        = s_axis_tdata;
    assign is_letter = (ch >= C_UPPER_A && ch <= C_UPPER_Z)
                    || (ch >= C_LOWER_A && ch <= C_LOWER_Z);
    assign is_blank  = (ch == C_SPACE) || (ch >= C_TAB && ch <= C_CR);
    assign is_mark   = (ch == C_PERIOD) || (ch == C_BANG) || (ch == C_QUESTION);

    always_comb begin
        letter_next = is_letter ? sat_inc(letter_reg) : letter_reg;
        sent_next   = is_mark ? sat_inc(sent_reg) : sent_reg;
        word_next   = (!is_blank && !inword_reg) ? sat_inc(word_reg) : word_reg;
        inword_next = !is_blank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_reg <= '0;
            word_reg   <= '0;
            sent_reg   <= '0;
            inword_reg <= 1'b0;
        end else if (cmd.count_en) begin
            if (cmd.snap) begin
                letter_reg <= '0;
                word_reg   <= '0;
                sent_reg   <= '0;
                inword_reg <= 1'b0;
            end else begin
                letter_reg <= letter_next;
                word_reg   <= word_next;
                sent_reg   <= sent_next;
                inword_reg <= inword_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            l_op_reg <= letter_next;
            w_op_reg <= word_next;
            s_op_reg <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_l_reg <= PL_W'(l_op_reg) * PL_W'(C_LETTER_COEF);
            prod_s_reg <= PS_W'(s_op_reg) * PS_W'(C_SENTENCE_COEF);
        end
    end

    assign num     = $signed(NUM_W'(prod_l_reg)) - $signed(NUM_W'(prod_s_reg));
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // Restoring division of the numerator magnitude by the word count, one bit per cycle.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, w_op_reg};

    always_comb begin
        if (!trial[COUNT_BITS]) begin
            rem_next = trial[COUNT_BITS-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[COUNT_BITS-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_load) begin
            cnt_reg <= CNT_W'(NUM_W);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            neg_reg <= num[NUM_W-1];
            rem_reg <= '0;
            quo_reg <= num_mag;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.div_last = (cnt_reg == CNT_W'(1));

    assign q_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge aclk) begin
        if (cmd.adj_en) begin
            t_reg <= T_W'(q_signed) - $signed(T_W'(C_GRADE_OFFSET));
        end
    end

    always_comb begin
        grade = '0;
        if (!t_reg[T_W-1]) begin
            for (int k = 1; k <= C_GRADE_MAX; k++) begin
                if (t_reg >= $signed(T_W'(C_GRADE_STEP * k))) begin
                    grade = GRADE_W'(k);
                end
            end
        end
    end

    assign no_words = (w_op_reg == '0);

    generate
        if (COUNT_BITS > OUT_W) begin : g_clip
            assign letter_out = (|l_op_reg[COUNT_BITS-1:OUT_W]) ? '1 : l_op_reg[OUT_W-1:0];
            assign word_out   = (|w_op_reg[COUNT_BITS-1:OUT_W]) ? '1 : w_op_reg[OUT_W-1:0];
            assign sent_out   = (|s_op_reg[COUNT_BITS-1:OUT_W]) ? '1 : s_op_reg[OUT_W-1:0];
        end else begin : g_extend
            assign letter_out = OUT_W'(l_op_reg);
            assign word_out   = OUT_W'(w_op_reg);
            assign sent_out   = OUT_W'(s_op_reg);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {{PAD_W{1'b0}}, (no_words ? GRADE_W'(0) : grade),
                             sent_out, word_out, letter_out};
            out_user_reg <= no_words;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

>>> rtl/core/trg_checker.sv
module trg_checker
    import trg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result transaction dropped while stalled.");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result payload changed while stalled.");

    a_no_words_grade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[52:48] == 5'd0)
        else $error("Grade is nonzero with no words.");

    a_grade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[52:48] <= 5'd16)
        else $error("Grade is out of range.");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("Input accepted while the grade is computed.");

endmodule

bind text_readability_grader_unit trg_checker u_trg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> dv/tb_top.sv
module tb_top;
    import trg_pkg::*;

    localparam int CNT_BITS       = 16;
    localparam int RANDOM_BYTES   = 1100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 60;

    typedef logic [CNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [OUT_W-1:0]   letters;
        logic [OUT_W-1:0]   words;
        logic [OUT_W-1:0]   sentences;
        logic [GRADE_W-1:0] grade;
        logic               no_words;
    } grade_report_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          last;
        bit            typed;
        grade_report_t report;
    } script_row_t;

    localparam grade_report_t NO_REPORT = '0;

    // Short texts first: blank only, a one-byte word, a lone mark, a long word that
    // clamps the grade high, then a mix of class boundaries ending on whitespace.
    localparam script_row_t SCRIPT [25] = '{
        '{C_SPACE,    1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 5'd0, 1'b1}},
        '{C_UPPER_A,  1'b1, 1'b1, '{16'd1, 16'd1, 16'd0, 5'd0, 1'b0}},
        '{C_QUESTION, 1'b1, 1'b1, '{16'd0, 16'd1, 16'd1, 5'd0, 1'b0}},
        '{C_UPPER_Z,  1'b0, 1'b0, NO_REPORT},
        '{C_LOWER_Z,  1'b0, 1'b0, NO_REPORT},
        '{C_UPPER_A,  1'b0, 1'b0, NO_REPORT},
        '{C_LOWER_A,  1'b0, 1'b0, NO_REPORT},
        '{C_UPPER_Z,  1'b0, 1'b0, NO_REPORT},
        '{C_LOWER_Z,  1'b1, 1'b1, '{16'd6, 16'd1, 16'd0, 5'd16, 1'b0}},
        '{8'd0,       1'b0, 1'b0, NO_REPORT},
        '{8'd255,     1'b0, 1'b0, NO_REPORT},
        '{C_TAB,      1'b0, 1'b0, NO_REPORT},
        '{8'd64,      1'b0, 1'b0, NO_REPORT},
        '{8'd91,      1'b0, 1'b0, NO_REPORT},
        '{8'd8,       1'b0, 1'b0, NO_REPORT},
        '{8'd96,      1'b0, 1'b0, NO_REPORT},
        '{8'd123,     1'b0, 1'b0, NO_REPORT},
        '{8'd14,      1'b0, 1'b0, NO_REPORT},
        '{C_BANG,     1'b0, 1'b0, NO_REPORT},
        '{8'd10,      1'b0, 1'b0, NO_REPORT},
        '{C_PERIOD,   1'b0, 1'b0, NO_REPORT},
        '{8'd11,      1'b0, 1'b0, NO_REPORT},
        '{C_QUESTION, 1'b0, 1'b0, NO_REPORT},
        '{8'd12,      1'b0, 1'b0, NO_REPORT},
        '{C_CR,       1'b1, 1'b0, NO_REPORT}
    };

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    count_t seen_letters = '0;
    count_t seen_words   = '0;
    count_t seen_marks   = '0;
    bit     in_word      = 1'b0;

    grade_report_t pending_reports [$];

    bit          feed_steady     = 1'b0;
    bit          drain_steady    = 1'b0;
    int unsigned bytes_sent      = 0;
    int unsigned reports_checked = 0;
    int unsigned empty_reports   = 0;
    int unsigned error_count     = 0;
    int unsigned stall_cycles    = 0;

    text_readability_grader_unit #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic count_t bump(count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] to_report(count_t v);
        return (longint'(v) > 65535) ? 16'hFFFF : OUT_W'(v);
    endfunction

    function automatic logic [GRADE_W-1:0] coleman_liau_grade(longint letters, longint words,
                                                              longint marks);
        longint num;
        longint t;
        longint g;
        num = letters * 588 - marks * 2960;
        t = num / words - 1530;
        g = t / 100;
        if (g < 0) begin
            g = 0;
        end
        if (g > 16) begin
            g = 16;
        end
        return GRADE_W'(g);
    endfunction

    function automatic bit absorb_char(input logic [7:0] ch, input logic last,
                                       output grade_report_t rep);
        bit blank;
        bit letter;
        blank  = (ch == C_SPACE) || (ch >= C_TAB && ch <= C_CR);
        letter = (ch >= C_UPPER_A && ch <= C_UPPER_Z) || (ch >= C_LOWER_A && ch <= C_LOWER_Z);
        rep = '0;
        if (letter) begin
            seen_letters = bump(seen_letters);
        end
        if (blank) begin
            in_word = 1'b0;
        end else begin
            if (!in_word) begin
                seen_words = bump(seen_words);
            end
            in_word = 1'b1;
        end
        if (ch == C_PERIOD || ch == C_BANG || ch == C_QUESTION) begin
            seen_marks = bump(seen_marks);
        end
        if (!last) begin
            return 1'b0;
        end
        rep.letters   = to_report(seen_letters);
        rep.words     = to_report(seen_words);
        rep.sentences = to_report(seen_marks);
        if (seen_words == '0) begin
            rep.no_words = 1'b1;
        end else begin
            rep.grade = coleman_liau_grade(longint'(seen_letters), longint'(seen_words),
                                           longint'(seen_marks));
        end
        seen_letters = '0;
        seen_words   = '0;
        seen_marks   = '0;
        in_word      = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] draw_char(int unsigned letter_pct, int unsigned mark_pct,
                                             int unsigned noise_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < letter_pct) begin
            if ($urandom_range(0, 1) == 0) begin
                return 8'($urandom_range(C_UPPER_A, C_UPPER_Z));
            end
            return 8'($urandom_range(C_LOWER_A, C_LOWER_Z));
        end else if (r < letter_pct + mark_pct) begin
            case ($urandom_range(0, 2))
                0: return C_PERIOD;
                1: return C_BANG;
                default: return C_QUESTION;
            endcase
        end else if (r < letter_pct + mark_pct + noise_pct) begin
            return 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(C_TAB, C_CR));
        end
        return C_SPACE;
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic last, input bit typed,
                             input grade_report_t typed_report);
        int unsigned   idle;
        grade_report_t rep;
        idle = pick_gap(feed_steady);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent++;
        if (absorb_char(ch, last, rep)) begin
            pending_reports.push_back(typed ? typed_report : rep);
        end
    endtask

    task automatic send_text(int unsigned len, int unsigned letter_pct, int unsigned mark_pct,
                             int unsigned noise_pct);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(draw_char(letter_pct, mark_pct, noise_pct), i == len - 1, 1'b0, NO_REPORT);
        end
    endtask

    task automatic check_report(grade_report_t want);
        grade_report_t got;
        got.letters   = m_axis_tdata[15:0];
        got.words     = m_axis_tdata[31:16];
        got.sentences = m_axis_tdata[47:32];
        got.grade     = m_axis_tdata[52:48];
        got.no_words  = m_axis_tuser;
        if (got.letters !== want.letters) begin
            $display("%0t letter_total mismatch: expected %0d actual %0d",
                     $time, want.letters, got.letters);
            error_count++;
        end
        if (got.words !== want.words) begin
            $display("%0t word_total mismatch: expected %0d actual %0d",
                     $time, want.words, got.words);
            error_count++;
        end
        if (got.sentences !== want.sentences) begin
            $display("%0t sentence_total mismatch: expected %0d actual %0d",
                     $time, want.sentences, got.sentences);
            error_count++;
        end
        if (got.grade !== want.grade) begin
            $display("%0t grade mismatch: expected %0d actual %0d", $time, want.grade, got.grade);
            error_count++;
        end
        if (got.no_words !== want.no_words) begin
            $display("%0t no_words mismatch: expected %0b actual %0b",
                     $time, want.no_words, got.no_words);
            error_count++;
        end
        if (m_axis_tdata[M_TDATA_W-1:53] !== '0) begin
            $display("%0t tdata padding mismatch: expected 0 actual %0h",
                     $time, m_axis_tdata[M_TDATA_W-1:53]);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t result transaction with no report expected: tdata %0h tuser %0b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                if (pending_reports[0].no_words) begin
                    empty_reports++;
                end
                check_report(pending_reports.pop_front());
                reports_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned idle;
        int unsigned hold;
        @(posedge aclk);
        forever begin
            idle = pick_gap(drain_steady);
            if (idle > 0) begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            hold = $urandom_range(1, 12);
            repeat (hold) @(posedge aclk);
            if ($urandom_range(0, 15) == 0) begin
                drain_steady = !drain_steady;
            end
        end
    end

    initial begin
        int unsigned len;
        int unsigned letter_pct;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i]) begin
            send_byte(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].report);
        end

        while (bytes_sent < $size(SCRIPT) + RANDOM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                feed_steady = !feed_steady;
            end
            if ($urandom_range(0, 11) == 0) begin
                send_text($urandom_range(1, 4), 0, 0, 0);
            end else begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
                letter_pct = $urandom_range(40, 85);
                send_text(len, letter_pct, $urandom_range(0, 12), $urandom_range(0, 8));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d text bytes and %0d checked grade reports.",
                 bytes_sent, reports_checked);
        $display("That includes %0d texts without words and random gaps on both sides.",
                 empty_reports);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> text_readability_grader_unit.f
rtl/core/trg_pkg.sv
rtl/core/trg_controller.sv
rtl/core/trg_datapath.sv
rtl/core/text_readability_grader_unit.sv
rtl/core/trg_checker.sv
dv/tb_top.sv
